// ===== design/gdbrx_pkg.sv =====
package gdbrx_pkg;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_PAYLOAD = 3'd1,
        PH_ESCAPE  = 3'd2,
        PH_HEX_HI  = 3'd3,
        PH_HEX_LO  = 3'd4
    } phase_t;

    // Event codes carried in tuser.
    localparam logic [2:0] EV_DATA     = 3'd0;
    localparam logic [2:0] EV_OK       = 3'd1;
    localparam logic [2:0] EV_BAD      = 3'd2;
    localparam logic [2:0] EV_OVERFLOW = 3'd3;
    localparam logic [2:0] EV_RESTART  = 3'd4;
    localparam logic [2:0] EV_STRAY    = 3'd5;

    localparam logic [7:0] CH_START = 8'h24;  // '$'
    localparam logic [7:0] CH_END   = 8'h23;  // '#'
    localparam logic [7:0] CH_ESC   = 8'h7D;  // '}'
    localparam logic [7:0] ESC_XOR  = 8'h20;

    localparam int         LEN_W     = 10;
    localparam logic [9:0] MAX_RESET = 10'd511;

    typedef struct packed {
        phase_t           phase;
        logic [7:0]       sum;
        logic [LEN_W-1:0] count;
        logic [3:0]       chk_hi;
        logic             dig_bad;
    } rx_state_t;

    typedef struct packed {
        logic             valid;
        logic [2:0]       kind;
        logic [7:0]       data;
        logic [LEN_W-1:0] len;
        logic             last;
    } rx_result_t;

    // Returns {invalid, value}; a byte that is not a hex digit decodes as zero.
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = {1'b1, 4'd0};
        if (b >= 8'h30 && b <= 8'h39)
            r = {1'b0, 4'(b - 8'h30)};
        else if (b >= 8'h41 && b <= 8'h46)
            r = {1'b0, 4'(b - 8'h37)};
        else if (b >= 8'h61 && b <= 8'h66)
            r = {1'b0, 4'(b - 8'h57)};
        return r;
    endfunction

endpackage

// ===== design/gdbrx_step.sv =====
module gdbrx_step
(
    input  gdbrx_pkg::rx_state_t              st,
    input  logic [7:0]                        rx_byte,
    input  logic [gdbrx_pkg::LEN_W-1:0]       max_payload,
    output gdbrx_pkg::rx_state_t              st_next,
    output gdbrx_pkg::rx_result_t             res
);

    logic [4:0]                    hex;
    logic [7:0]                    sum_add;
    logic [7:0]                    data_val;
    logic [gdbrx_pkg::LEN_W:0]     count_inc;
    logic                          overflow;
    logic                          take;

    always_comb
    begin
        hex       = gdbrx_pkg::hex_decode(rx_byte);
        sum_add   = st.sum + rx_byte;
        data_val  = (st.phase == gdbrx_pkg::PH_ESCAPE) ? (rx_byte ^ gdbrx_pkg::ESC_XOR)
                                                       : rx_byte;
        count_inc = {1'b0, st.count} + (gdbrx_pkg::LEN_W+1)'(1);
        overflow  = count_inc > {1'b0, max_payload};
        take      = 1'b0;
        st_next   = st;
        res       = '0;

        unique case (st.phase)
            gdbrx_pkg::PH_PAYLOAD:
            begin
                if (rx_byte == gdbrx_pkg::CH_END)
                begin
                    st_next.phase = gdbrx_pkg::PH_HEX_HI;
                end
                else if (rx_byte == gdbrx_pkg::CH_START)
                begin
                    // Restart: drop the partial payload but stay inside a packet.
                    res.valid     = 1'b1;
                    res.kind      = gdbrx_pkg::EV_RESTART;
                    res.len       = st.count;
                    res.last      = 1'b1;
                    st_next.sum   = '0;
                    st_next.count = '0;
                end
                else
                begin
                    st_next.sum = sum_add;
                    if (rx_byte == gdbrx_pkg::CH_ESC)
                        st_next.phase = gdbrx_pkg::PH_ESCAPE;
                    else
                        take = 1'b1;
                end
            end
            gdbrx_pkg::PH_ESCAPE:
            begin
                st_next.sum = sum_add;
                take        = 1'b1;
            end
            gdbrx_pkg::PH_HEX_HI:
            begin
                st_next.chk_hi  = hex[3:0];
                st_next.dig_bad = hex[4];
                st_next.phase   = gdbrx_pkg::PH_HEX_LO;
            end
            gdbrx_pkg::PH_HEX_LO:
            begin
                st_next.phase = gdbrx_pkg::PH_IDLE;
                res.valid     = 1'b1;
                res.len       = st.count;
                res.last      = 1'b1;
                if (!hex[4] && !st.dig_bad && {st.chk_hi, hex[3:0]} == st.sum)
                    res.kind = gdbrx_pkg::EV_OK;
                else
                    res.kind = gdbrx_pkg::EV_BAD;
            end
            default:
            begin
                if (rx_byte == gdbrx_pkg::CH_START)
                begin
                    st_next.phase   = gdbrx_pkg::PH_PAYLOAD;
                    st_next.sum     = '0;
                    st_next.count   = '0;
                    st_next.chk_hi  = '0;
                    st_next.dig_bad = 1'b0;
                end
                else
                begin
                    st_next.phase = gdbrx_pkg::PH_IDLE;
                    res.valid     = 1'b1;
                    res.kind      = gdbrx_pkg::EV_STRAY;
                    res.data      = rx_byte;
                end
            end
        endcase

        if (take)
        begin
            res.valid = 1'b1;
            if (overflow)
            begin
                st_next.phase = gdbrx_pkg::PH_IDLE;
                res.kind      = gdbrx_pkg::EV_OVERFLOW;
                res.len       = max_payload;
                res.last      = 1'b1;
            end
            else
            begin
                st_next.phase = gdbrx_pkg::PH_PAYLOAD;
                st_next.count = count_inc[gdbrx_pkg::LEN_W-1:0];
                res.kind      = gdbrx_pkg::EV_DATA;
                res.data      = data_val;
                res.len       = count_inc[gdbrx_pkg::LEN_W-1:0];
            end
        end
    end

endmodule

// ===== design/gdb_packet_deframer_rx.sv =====
// Channel   | Direction | Contents
// s_axis    | in        | tdata[7:0] rx_byte
// m_axis    | out       | tdata[7:0] data_byte, [17:8] payload_length; tuser event_kind;
//           |           | tlast packet_end
// cfg       | in        | data[9:0] max_payload
//
// One byte is taken every cycle when ready; its event, if any, appears in the output
// register on the next cycle. The framing state updates in the same cycle the byte is
// accepted. s_axis_tready drops only while the output register holds an event that
// m_axis has not taken. Reset returns to idle (waiting for '$') with max_payload = 511.
module gdb_packet_deframer_rx
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] data_byte, [17:8] payload_length, rest zero
    output logic [2:0]  m_axis_tuser,   // [2:0] event_kind
    output logic        m_axis_tlast,   // packet_end

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [9:0]  cfg_data        // [9:0] max_payload
);

    gdbrx_pkg::rx_state_t              state_reg;
    gdbrx_pkg::rx_state_t              state_next;
    gdbrx_pkg::rx_result_t             res;
    logic [gdbrx_pkg::LEN_W-1:0]       max_payload_reg;
    logic                              out_valid_reg;
    logic [2:0]                        out_kind_reg;
    logic [7:0]                        out_data_reg;
    logic [gdbrx_pkg::LEN_W-1:0]       out_len_reg;
    logic                              out_last_reg;
    logic                              accept;

    gdbrx_step u_step
    (
        .st          (state_reg),
        .rx_byte     (s_axis_tdata),
        .max_payload (max_payload_reg),
        .st_next     (state_next),
        .res         (res)
    );

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= '{phase: gdbrx_pkg::PH_IDLE, default: '0};
            max_payload_reg <= gdbrx_pkg::MAX_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                max_payload_reg <= cfg_data;
            if (accept)
            begin
                state_reg     <= state_next;
                out_valid_reg <= res.valid;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_kind_reg <= res.kind;
            out_data_reg <= res.data;
            out_len_reg  <= res.len;
            out_last_reg <= res.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_len_reg, out_data_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // Only ok, bad, overflow and restart events close a packet.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast ==
            (m_axis_tuser == gdbrx_pkg::EV_OK || m_axis_tuser == gdbrx_pkg::EV_BAD ||
             m_axis_tuser == gdbrx_pkg::EV_OVERFLOW || m_axis_tuser == gdbrx_pkg::EV_RESTART)))
        else $error("tlast does not match event kind");

    // Data byte is zero except for payload and stray events.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != gdbrx_pkg::EV_DATA &&
         m_axis_tuser != gdbrx_pkg::EV_STRAY) |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("nonzero data byte on a framing event");

    // A byte that opens a packet from idle never produces an event.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && state_reg.phase == gdbrx_pkg::PH_IDLE &&
         s_axis_tdata == gdbrx_pkg::CH_START) |=> !m_axis_tvalid)
        else $error("event produced for opening start byte");

    // Stray bytes carry a zero length and never arrive inside a packet.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == gdbrx_pkg::EV_STRAY) |->
            (m_axis_tdata[17:8] == 10'd0 && state_reg.phase == gdbrx_pkg::PH_IDLE))
        else $error("stray event with inconsistent state");
`endif

endmodule
